// File: rtl/core/ttp_pkg.sv
// shared widths, constants, register codes and the cordic angle table for the tilt tracker
package ttp_pkg;

  localparam int RING_DEPTH  = 5;
  localparam int SAMPLE_BITS = 16;
  localparam int SLOT_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W       = SAMPLE_BITS + $clog2(RING_DEPTH) + 1;
  localparam int SQ_W        = 2 * SUM_W;

  localparam int POS_W   = 10;
  localparam int PITCH_W = 16;
  localparam int ANG_W   = 17;
  localparam int INC_W   = 16;
  localparam int MAG_W   = 15;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_LEFT_LIMIT  = 1'b0;
  localparam logic REG_RIGHT_LIMIT = 1'b1;

  localparam int OP_W          = 32;
  localparam int CX_W          = 34;
  localparam int ACC_W         = 27;
  localparam int CORDIC_STEPS  = 23;
  localparam int STEP_W        = 5;
  localparam int TAB_W         = 22;

  localparam int PITCH_MAX      = 23040;
  localparam int ROLL_MAX       = 46080;
  localparam int HALF_TURN_FINE = 180 * 65536;

  localparam int S_W        = 60;
  localparam int ROOT_W     = S_W / 2;
  localparam int REM_W      = ROOT_W + 4;
  localparam int NORM_LIMIT = 40;
  localparam int K_W        = 6;
  localparam int CNT_W      = 5;

  localparam longint INC_DIVISOR = 64'd458752000;
  localparam int     DIV_BITS    = 16;
  localparam int     NUM_W       = 46;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] z;
  } sample_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic [TAB_W-1:0] angle_step(input logic [STEP_W-1:0] i);
    logic [TAB_W-1:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/tilt_to_position_tracker_top.sv
// tilt tracker top: sample ring, running sums, square root, cube and position update
//
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | in_accel_x, in_accel_y, in_accel_z
//  out     | out_valid / out_ready | out_position, out_pitch_angle, out_roll_angle,
//          |                       | out_step_increment
//  config  | psel, penable, pwrite | paddr, pwdata, prdata, pready (always high)
//
// one item at a time: 12 to 40 normalize steps and 30 two-bit square root steps,
// then the shared cordic (scaling steps and 23 rotations) and a 16-step restoring
// divide for the increment.
// the roll cordic runs alongside the square root pass.
// rst_n is synchronous; the ring, sums, position and limits come out of reset cleared
// (right limit at its top value). a result waiting on out_ready does not stop the next
// item from being taken; only the final load waits for the output register to free up.
module tilt_to_position_tracker_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ttp_pkg::SAMPLE_BITS-1:0] in_accel_x,
  input  logic signed [ttp_pkg::SAMPLE_BITS-1:0] in_accel_y,
  input  logic signed [ttp_pkg::SAMPLE_BITS-1:0] in_accel_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [ttp_pkg::POS_W-1:0]              out_position,
  output logic signed [ttp_pkg::PITCH_W-1:0]     out_pitch_angle,
  output logic signed [ttp_pkg::ANG_W-1:0]       out_roll_angle,
  output logic signed [ttp_pkg::INC_W-1:0]       out_step_increment,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ttp_pkg::ADDR_W-1:0]             paddr,
  input  logic [ttp_pkg::DATA_W-1:0]             pwdata,
  output logic [ttp_pkg::DATA_W-1:0]             prdata,
  output logic                                   pready
);
  import ttp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQY   = 4'd1;
  localparam logic [3:0] S_SQZ   = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_NORM  = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_PITCH = 4'd6;
  localparam logic [3:0] S_PWAIT = 4'd7;
  localparam logic [3:0] S_CUBE1 = 4'd8;
  localparam logic [3:0] S_CUBE2 = 4'd9;
  localparam logic [3:0] S_BIAS  = 4'd10;
  localparam logic [3:0] S_DIV   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  localparam logic [S_W-1:0]          S_BOUND   = S_W'(64'd1 << 58);
  localparam logic signed [OP_W-1:0]  X_BOUND   = OP_W'(1 << 29);
  localparam logic [NUM_W-1:0]        HALF_DIV  = NUM_W'(INC_DIVISOR / 2);
  localparam logic [NUM_W-1:0]        DIV_TOP   = NUM_W'(INC_DIVISOR << (DIV_BITS - 1));
  localparam logic signed [ANG_W-1:0] PITCH_LIM = ANG_W'(PITCH_MAX);

  logic [3:0]                state_r, state_nxt;
  sample_t                   ring_r [RING_DEPTH];
  sample_t                   old_s;
  logic [SLOT_W-1:0]         slot_r, slot_nxt;
  logic signed [SUM_W-1:0]   sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt, sum_z_r, sum_z_nxt;
  logic [POS_W-1:0]          left_r, right_r, pos_r, pos_nxt;
  logic                      out_valid_r, out_valid_nxt, load;
  logic                      cfg_wr;

  logic [SQ_W-1:0]           sq_r, sq_nxt;
  logic [S_W-1:0]            s_r, s_nxt;
  logic signed [OP_W-1:0]    xq_r, xq_nxt;
  logic [K_W-1:0]            k_r, k_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt, rem_t, trial;
  logic [ROOT_W-1:0]         root_r, root_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [ANG_W-1:0]   roll_r, roll_nxt;
  logic signed [PITCH_W-1:0] pitch_r, pitch_nxt;
  logic [NUM_W-1:0]          prod_r, prod_nxt, dv_r, dv_nxt;
  logic [DIV_BITS-1:0]       q_r, q_nxt;

  logic signed [SUM_W-1:0]   mul_sel;
  logic [SUM_W-1:0]          mul_mag;
  logic [SQ_W-1:0]           mul_out;
  logic [MAG_W-1:0]          pmag;
  logic signed [INC_W-1:0]   inc;
  logic signed [POS_W+1:0]   pos_sum;

  logic                      cd_start, cd_busy;
  logic signed [OP_W-1:0]    cd_x, cd_y;
  logic signed [ANG_W-1:0]   cd_angle;

  logic [POS_W-1:0]          o_pos_r;
  logic signed [PITCH_W-1:0] o_pitch_r;
  logic signed [ANG_W-1:0]   o_roll_r;
  logic signed [INC_W-1:0]   o_inc_r;

  ttp_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cd_start),
    .x_in  (cd_x),
    .y_in  (cd_y),
    .busy  (cd_busy),
    .angle (cd_angle)
  );

  assign in_ready = (state_r == S_IDLE);
  assign old_s    = ring_r[slot_r];
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign pready   = 1'b1;

  // squares share one multiplier on the magnitude of the sum
  assign mul_sel = (state_r == S_SQY) ? sum_y_r : sum_z_r;
  assign mul_mag = mul_sel[SUM_W-1] ? SUM_W'(-mul_sel) : SUM_W'(mul_sel);
  assign mul_out = SQ_W'(mul_mag) * SQ_W'(mul_mag);

  assign pmag = pitch_r[PITCH_W-1] ? MAG_W'(-pitch_r) : MAG_W'(pitch_r);

  assign cd_start = (state_r == S_SQY) || (state_r == S_PITCH && !cd_busy);
  assign cd_x = (state_r == S_SQY) ? OP_W'(sum_z_r) : OP_W'(signed'({2'b00, root_r}));
  assign cd_y = (state_r == S_SQY) ? OP_W'(sum_y_r) : xq_r;

  assign rem_t = {rem_r[REM_W-3:0], s_r[S_W-1:S_W-2]};
  assign trial = REM_W'({root_r, 2'b01});

  assign inc     = pitch_r[PITCH_W-1] ? -INC_W'(q_r) : INC_W'(q_r);
  assign pos_sum = signed'({2'b00, pos_r}) + (POS_W+2)'(inc >>> 8);

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_LEFT_LIMIT:  prdata = DATA_W'(left_r);
      REG_RIGHT_LIMIT: prdata = DATA_W'(right_r);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    sum_z_nxt = sum_z_r;
    sq_nxt    = sq_r;
    s_nxt     = s_r;
    xq_nxt    = xq_r;
    k_nxt     = k_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    roll_nxt  = roll_r;
    pitch_nxt = pitch_r;
    prod_nxt  = prod_r;
    dv_nxt    = dv_r;
    q_nxt     = q_r;
    pos_nxt   = pos_r;
    load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // running sums: add the new item, drop the one it overwrites
          sum_x_nxt = sum_x_r + SUM_W'(in_accel_x) - SUM_W'(old_s.x);
          sum_y_nxt = sum_y_r + SUM_W'(in_accel_y) - SUM_W'(old_s.y);
          sum_z_nxt = sum_z_r + SUM_W'(in_accel_z) - SUM_W'(old_s.z);
          slot_nxt  = (slot_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;
          state_nxt = S_SQY;
        end
      end
      S_SQY: begin
        sq_nxt    = mul_out;
        state_nxt = S_SQZ;
      end
      S_SQZ: begin
        s_nxt     = S_W'(mul_out);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        s_nxt     = s_r + S_W'(sq_r);
        xq_nxt    = -OP_W'(sum_x_r);
        k_nxt     = '0;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (k_r < K_W'(NORM_LIMIT) && s_r < S_BOUND && xq_r < X_BOUND && xq_r > -X_BOUND) begin
          s_nxt  = s_r << 2;
          xq_nxt = xq_r <<< 1;
          k_nxt  = k_r + 1'b1;
        end else begin
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        // two radicand bits per cycle, one root bit out
        if (rem_t >= trial) begin
          rem_nxt  = rem_t - trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_t;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        s_nxt = s_r << 2;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          state_nxt = S_PITCH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_PITCH: begin
        if (!cd_busy) begin
          roll_nxt  = cd_angle;
          state_nxt = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (!cd_busy) begin
          if (cd_angle > PITCH_LIM) begin
            pitch_nxt = PITCH_W'(PITCH_MAX);
          end else if (cd_angle < -PITCH_LIM) begin
            pitch_nxt = -PITCH_W'(PITCH_MAX);
          end else begin
            pitch_nxt = PITCH_W'(cd_angle);
          end
          state_nxt = S_CUBE1;
        end
      end
      S_CUBE1: begin
        prod_nxt  = NUM_W'((2*MAG_W)'(pmag) * (2*MAG_W)'(pmag));
        state_nxt = S_CUBE2;
      end
      S_CUBE2: begin
        prod_nxt  = NUM_W'(prod_r[2*MAG_W-1:0]) * NUM_W'(pmag);
        state_nxt = S_BIAS;
      end
      S_BIAS: begin
        // round half away from zero on the magnitude
        prod_nxt  = prod_r + HALF_DIV;
        dv_nxt    = DIV_TOP;
        q_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (prod_r >= dv_r) begin
          prod_nxt = prod_r - dv_r;
          q_nxt    = {q_r[DIV_BITS-2:0], 1'b1};
        end else begin
          q_nxt    = {q_r[DIV_BITS-2:0], 1'b0};
        end
        dv_nxt = dv_r >> 1;
        if (cnt_r == CNT_W'(DIV_BITS - 1)) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          load = 1'b1;
          // right bound first, so crossed limits settle on the left one
          if (pos_sum > signed'({2'b00, right_r})) begin
            pos_nxt = right_r;
          end else begin
            pos_nxt = POS_W'(pos_sum);
          end
          if (pos_sum > signed'({2'b00, right_r})
              ? (right_r < left_r)
              : (pos_sum < signed'({2'b00, left_r}))) begin
            pos_nxt = left_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      pos_r       <= '0;
      left_r      <= '0;
      right_r     <= '1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      sum_z_r     <= sum_z_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_valid && in_ready) begin
        ring_r[slot_r] <= '{x: in_accel_x, y: in_accel_y, z: in_accel_z};
      end
      if (cfg_wr) begin
        if (paddr[2] == REG_LEFT_LIMIT) begin
          left_r <= pwdata[POS_W-1:0];
        end else begin
          right_r <= pwdata[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_r    <= sq_nxt;
    s_r     <= s_nxt;
    xq_r    <= xq_nxt;
    k_r     <= k_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    cnt_r   <= cnt_nxt;
    roll_r  <= roll_nxt;
    pitch_r <= pitch_nxt;
    prod_r  <= prod_nxt;
    dv_r    <= dv_nxt;
    q_r     <= q_nxt;
    if (load) begin
      o_pos_r   <= pos_nxt;
      o_pitch_r <= pitch_r;
      o_roll_r  <= roll_r;
      o_inc_r   <= inc;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_position       = o_pos_r;
  assign out_pitch_angle    = o_pitch_r;
  assign out_roll_angle     = o_roll_r;
  assign out_step_increment = o_inc_r;

endmodule

// File: rtl/core/ttp_cordic.sv
// iterative vectoring cordic: atan2(y, x) in q8.8 degrees, one rotation per cycle
module ttp_cordic (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [ttp_pkg::OP_W-1:0]  x_in,
  input  logic signed [ttp_pkg::OP_W-1:0]  y_in,
  output logic                             busy,
  output logic signed [ttp_pkg::ANG_W-1:0] angle
);
  import ttp_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;
  localparam logic [1:0] C_FIN  = 2'd3;

  localparam logic signed [CX_W-1:0]  NORM_BOUND = CX_W'(1 << 29);
  localparam logic signed [ACC_W-1:0] HALF_TURN  = ACC_W'(HALF_TURN_FINE);
  localparam logic signed [ACC_W-1:0] ROLL_LIM   = ACC_W'(ROLL_MAX);
  localparam logic signed [ANG_W-1:0] ROLL_ANG   = ANG_W'(ROLL_MAX);
  localparam logic signed [ANG_W-1:0] PITCH_ANG  = ANG_W'(PITCH_MAX);

  logic [1:0]               state_r, state_nxt;
  logic signed [CX_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic signed [ANG_W-1:0]  angle_r, angle_nxt;
  logic signed [CX_W-1:0]   dx, dy;
  logic signed [ACC_W-1:0]  tab, rnd;

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    acc_nxt   = acc_r;
    step_nxt  = step_r;
    angle_nxt = angle_r;
    dx        = y_r >>> step_r;
    dy        = x_r >>> step_r;
    tab       = ACC_W'(signed'({1'b0, angle_step(step_r)}));
    rnd       = (acc_r + ACC_W'(128)) >>> 8;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          if (y_in == 0) begin
            angle_nxt = (x_in < 0) ? ROLL_ANG : '0;
          end else if (x_in == 0) begin
            angle_nxt = (y_in > 0) ? PITCH_ANG : -PITCH_ANG;
          end else begin
            state_nxt = C_NORM;
            if (x_in < 0) begin
              // reflect into the right half plane, add back a half turn at the end
              x_nxt   = -CX_W'(x_in);
              y_nxt   = -CX_W'(y_in);
              acc_nxt = (y_in >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
              x_nxt   = CX_W'(x_in);
              y_nxt   = CX_W'(y_in);
              acc_nxt = '0;
            end
          end
        end
      end
      C_NORM: begin
        if (x_r < NORM_BOUND && y_r < NORM_BOUND && y_r > -NORM_BOUND) begin
          x_nxt = x_r <<< 1;
          y_nxt = y_r <<< 1;
        end else begin
          state_nxt = C_ITER;
          step_nxt  = '0;
        end
      end
      C_ITER: begin
        if (y_r > 0) begin
          x_nxt   = x_r + dx;
          y_nxt   = y_r - dy;
          acc_nxt = acc_r + tab;
        end else begin
          x_nxt   = x_r - dx;
          y_nxt   = y_r + dy;
          acc_nxt = acc_r - tab;
        end
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = C_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      C_FIN: begin
        if (rnd > ROLL_LIM) begin
          angle_nxt = ROLL_ANG;
        end else if (rnd < -ROLL_LIM) begin
          angle_nxt = -ROLL_ANG;
        end else begin
          angle_nxt = ANG_W'(rnd);
        end
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      angle_r <= '0;
    end else begin
      state_r <= state_nxt;
      angle_r <= angle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    acc_r  <= acc_nxt;
    step_r <= step_nxt;
  end

  assign busy  = (state_r != C_IDLE);
  assign angle = angle_r;

endmodule

// File: rtl/core/ttp_checker.sv
// port-level checks for the tilt tracker, bound to the top level
module ttp_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic [ttp_pkg::POS_W-1:0]              out_position,
  input logic signed [ttp_pkg::PITCH_W-1:0]     out_pitch_angle,
  input logic signed [ttp_pkg::ANG_W-1:0]       out_roll_angle,
  input logic signed [ttp_pkg::INC_W-1:0]       out_step_increment
);
  import ttp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_position)
      && $stable(out_pitch_angle) && $stable(out_roll_angle)
      && $stable(out_step_increment))
    else $error("stalled result changed");

  // one item in flight: an accepted item blocks the input next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_angle <= PITCH_W'(PITCH_MAX)
      && out_pitch_angle >= -PITCH_W'(PITCH_MAX))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_angle <= ANG_W'(ROLL_MAX)
      && out_roll_angle >= -ANG_W'(ROLL_MAX))
    else $error("roll out of range");

endmodule

bind tilt_to_position_tracker_top ttp_checker u_ttp_checker (.*);
